[rtl/multipath_link_selector_defines.svh]
// Assertion helpers shared by the selector RTL
`ifndef MULTIPATH_LINK_SELECTOR_DEFINES_SVH
`define MULTIPATH_LINK_SELECTOR_DEFINES_SVH

// Check a same-cycle implication
`define MLS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("selector assertion failed");

// Check an implication in the following cycle
`define MLS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("selector assertion failed");

`endif

[rtl/mls_pkg.sv]
package mls_pkg;

    localparam int SLOT_COUNT = 8;
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
    localparam int SCORE_W    = 12;
    localparam int PEN_W      = 19;

    localparam logic [2:0] CMD_ADD    = 3'd0;
    localparam logic [2:0] CMD_REMOVE = 3'd1;
    localparam logic [2:0] CMD_MEAS   = 3'd2;
    localparam logic [2:0] CMD_TICK   = 3'd3;
    localparam logic [2:0] CMD_EVAL   = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NO_PATH = 2'd2;
    localparam logic [1:0] ST_NO_HLTH = 2'd3;

    localparam logic [1:0] REG_LOSS_LIMIT = 2'd0;
    localparam logic [1:0] REG_MARGIN     = 2'd1;
    localparam logic [1:0] REG_AUTO_SW    = 2'd2;
    localparam logic [1:0] REG_STALE      = 2'd3;

    localparam logic [SCORE_W-1:0] SCORE_BASE = 12'd3200;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] gateway_addr;
        logic [15:0] target_path;
        logic [15:0] latency_in;
        logic [10:0] loss_in;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] result_path;
        logic        switched;
        logic [15:0] prior_path;
        logic [10:0] winning_score;
        logic [3:0]  removed_count;
    } res_t;

    // Transaction state that walks along the row of slot cells
    typedef struct packed {
        logic               live;
        item_t              item;
        logic [15:0]        new_id;
        logic [15:0]        active;
        logic               taken;
        logic [CNT_W-1:0]   count;
        logic               hit;
        logic               best_ok;
        logic [SCORE_W-1:0] top_score;
        logic [15:0]        best_id;
        logic               act_ok;
        logic [SCORE_W-1:0] act_score;
    } scan_t;

endpackage

[rtl/multipath_link_selector.sv]
// A transaction is registered into a head stage, then moves through the row of SLOT_COUNT
// slot cells one cell per cycle; the result is registered as it leaves the last cell.
// A new command is accepted only once the previous one has finished and busy is low.
// Reset: all slots empty, ids, active path and tick count zero, registers at defaults.
// The result strobe lasts one cycle; the receiver cannot stall it.
`include "multipath_link_selector_defines.svh"

module multipath_link_selector (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  mls_pkg::item_t  item,
    output logic            busy,
    output logic            done,
    output mls_pkg::res_t   result,
    input  logic            cfg_we,
    input  logic [1:0]      cfg_index,
    input  logic [31:0]     cfg_data
);

    logic [10:0] loss_limit_reg, loss_limit_next;
    logic [10:0] margin_reg, margin_next;
    logic        auto_sw_reg, auto_sw_next;
    logic [31:0] stale_reg, stale_next;

    logic [15:0] next_id_reg, next_id_next;
    logic [15:0] active_reg, active_next;
    logic [31:0] ticks_reg, ticks_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    mls_pkg::res_t  res_reg, res_next;
    mls_pkg::scan_t head_reg, head_next;
    mls_pkg::scan_t chain [mls_pkg::SLOT_COUNT];
    mls_pkg::scan_t tail;

    logic [mls_pkg::SCORE_W-1:0] cur_score;
    logic [mls_pkg::SCORE_W:0]   bar;
    logic                        accept;

    assign accept = start && !busy_reg;
    assign tail   = chain[mls_pkg::SLOT_COUNT-1];

    // Decode configuration writes
    always_comb
    begin
        loss_limit_next = loss_limit_reg;
        margin_next     = margin_reg;
        auto_sw_next    = auto_sw_reg;
        stale_next      = stale_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                mls_pkg::REG_LOSS_LIMIT: loss_limit_next = cfg_data[10:0];
                mls_pkg::REG_MARGIN:     margin_next     = cfg_data[10:0];
                mls_pkg::REG_AUTO_SW:    auto_sw_next    = cfg_data[0];
                mls_pkg::REG_STALE:      stale_next      = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Launch a transaction into the cell row
    always_comb
    begin
        head_next        = '0;
        head_next.live   = accept;
        head_next.item   = item;
        head_next.new_id = next_id_reg;
        head_next.active = active_reg;
    end

    // Build the cell row
    for (genvar g = 0; g < mls_pkg::SLOT_COUNT; g++)
    begin : g_cell
        if (g == 0)
        begin : g_first
            mls_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .loss_limit  (loss_limit_reg),
                .stale_limit (stale_reg),
                .now_ticks   (ticks_reg),
                .scan_in     (head_reg),
                .scan_out    (chain[g])
            );
        end
        else
        begin : g_rest
            mls_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .loss_limit  (loss_limit_reg),
                .stale_limit (stale_reg),
                .now_ticks   (ticks_reg),
                .scan_in     (chain[g-1]),
                .scan_out    (chain[g])
            );
        end
    end

    // Finish the transaction leaving the last cell
    always_comb
    begin
        next_id_next = next_id_reg;
        active_next  = active_reg;
        ticks_next   = ticks_reg;
        busy_next    = busy_reg;
        done_next    = 1'b0;
        res_next     = res_reg;
        cur_score    = tail.act_ok ? tail.act_score : '0;
        bar          = {1'b0, cur_score} + {1'b0, margin_reg, 1'b0};
        if (accept)
            busy_next = 1'b1;
        if (tail.live)
        begin
            busy_next = 1'b0;
            done_next = 1'b1;
            res_next  = '0;
            case (tail.item.cmd)
                mls_pkg::CMD_ADD:
                begin
                    if (tail.taken)
                    begin
                        res_next.result_path = tail.new_id;
                        next_id_next         = next_id_reg + 16'd1;
                    end
                    else
                        res_next.status = mls_pkg::ST_FULL;
                end
                mls_pkg::CMD_REMOVE:
                begin
                    res_next.removed_count = 4'(tail.count);
                    if (tail.count == '0)
                        res_next.status = mls_pkg::ST_NO_PATH;
                end
                mls_pkg::CMD_MEAS:
                begin
                    if (!tail.hit)
                        res_next.status = mls_pkg::ST_NO_PATH;
                end
                mls_pkg::CMD_TICK:
                begin
                    ticks_next = ticks_reg + 32'd1;
                end
                mls_pkg::CMD_EVAL:
                begin
                    res_next.prior_path = active_reg;
                    if (!tail.best_ok)
                        res_next.status = mls_pkg::ST_NO_HLTH;
                    else
                    begin
                        res_next.winning_score = tail.top_score[mls_pkg::SCORE_W-1:1];
                        if (auto_sw_reg && tail.best_id != active_reg &&
                            {1'b0, tail.top_score} > bar)
                        begin
                            active_next       = tail.best_id;
                            res_next.switched = 1'b1;
                        end
                    end
                    res_next.result_path = active_next;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loss_limit_reg <= 11'd80;
            margin_reg     <= 11'd80;
            auto_sw_reg    <= 1'b1;
            stale_reg      <= 32'd5000;
            next_id_reg    <= '0;
            active_reg     <= '0;
            ticks_reg      <= '0;
            busy_reg       <= 1'b0;
            done_reg       <= 1'b0;
            head_reg       <= '0;
        end
        else
        begin
            loss_limit_reg <= loss_limit_next;
            margin_reg     <= margin_next;
            auto_sw_reg    <= auto_sw_next;
            stale_reg      <= stale_next;
            next_id_reg    <= next_id_next;
            active_reg     <= active_next;
            ticks_reg      <= ticks_next;
            busy_reg       <= busy_next;
            done_reg       <= done_next;
            head_reg       <= head_next;
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = res_reg;

    `MLS_ASSERT_NEXT(a_strobe_single, done_reg, !done_reg)
    `MLS_ASSERT_NEXT(a_accept_busy, accept, busy_reg)
    `MLS_ASSERT_NOW(a_tail_from_busy, tail.live, busy_reg)
    `MLS_ASSERT_NOW(a_full_no_id, done_reg && res_reg.status == mls_pkg::ST_FULL,
                    res_reg.result_path == 16'd0)

endmodule

[rtl/mls_cell.sv]
module mls_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [10:0]       loss_limit,
    input  logic [31:0]       stale_limit,
    input  logic [31:0]       now_ticks,
    input  mls_pkg::scan_t    scan_in,
    output mls_pkg::scan_t    scan_out
);

    logic        valid_reg, valid_next;
    logic [15:0] id_reg;
    logic [31:0] gw_reg;
    logic [15:0] lat_reg;
    logic [15:0] jit_reg;
    logic [10:0] loss_reg;
    logic        healthy_reg;
    logic [31:0] stamp_reg;
    mls_pkg::scan_t scan_reg, scan_next;

    logic [mls_pkg::PEN_W-1:0]   pen;
    logic [mls_pkg::SCORE_W-1:0] score;
    logic                        stale;
    logic                        wr_add, wr_meas;
    logic [15:0]                 jit_new;

    // Score this slot in units of 1/32
    always_comb
    begin
        stale = (now_ticks - stamp_reg) > stale_limit;
        pen   = mls_pkg::PEN_W'(lat_reg)
              + mls_pkg::PEN_W'({jit_reg, 2'b00})
              + mls_pkg::PEN_W'({loss_reg, 4'b0000})
              + mls_pkg::PEN_W'({loss_reg, 2'b00})
              + (healthy_reg ? mls_pkg::PEN_W'(0) : mls_pkg::PEN_W'(1600))
              + (stale ? mls_pkg::PEN_W'(640) : mls_pkg::PEN_W'(0));
        if (pen >= mls_pkg::PEN_W'(mls_pkg::SCORE_BASE))
            score = '0;
        else
            score = mls_pkg::SCORE_BASE - pen[mls_pkg::SCORE_W-1:0];
    end

    // Act on the passing transaction
    always_comb
    begin
        scan_next  = scan_in;
        valid_next = valid_reg;
        wr_add     = 1'b0;
        wr_meas    = 1'b0;
        jit_new    = (scan_in.item.latency_in > lat_reg) ?
                     scan_in.item.latency_in - lat_reg : lat_reg - scan_in.item.latency_in;
        if (scan_in.live)
        begin
            case (scan_in.item.cmd)
                mls_pkg::CMD_ADD:
                begin
                    if (!valid_reg && !scan_in.taken)
                    begin
                        wr_add          = 1'b1;
                        valid_next      = 1'b1;
                        scan_next.taken = 1'b1;
                    end
                end
                mls_pkg::CMD_REMOVE:
                begin
                    if (valid_reg && gw_reg == scan_in.item.gateway_addr)
                    begin
                        valid_next      = 1'b0;
                        scan_next.count = scan_in.count + 1'b1;
                    end
                end
                mls_pkg::CMD_MEAS:
                begin
                    if (valid_reg && id_reg == scan_in.item.target_path)
                    begin
                        wr_meas       = 1'b1;
                        scan_next.hit = 1'b1;
                    end
                end
                mls_pkg::CMD_EVAL:
                begin
                    if (valid_reg && healthy_reg &&
                        (!scan_in.best_ok || score > scan_in.top_score ||
                         (score == scan_in.top_score && id_reg < scan_in.best_id)))
                    begin
                        scan_next.best_ok   = 1'b1;
                        scan_next.top_score = score;
                        scan_next.best_id   = id_reg;
                    end
                    if (valid_reg && id_reg == scan_in.active && !scan_in.act_ok)
                    begin
                        scan_next.act_ok    = 1'b1;
                        scan_next.act_score = score;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            scan_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            scan_reg  <= scan_next;
        end
    end

    // Write slot payload
    always_ff @(posedge clk)
    begin
        if (wr_add)
        begin
            id_reg      <= scan_in.new_id;
            gw_reg      <= scan_in.item.gateway_addr;
            lat_reg     <= '0;
            jit_reg     <= '0;
            loss_reg    <= '0;
            healthy_reg <= 1'b1;
            stamp_reg   <= now_ticks;
        end
        else if (wr_meas)
        begin
            lat_reg     <= scan_in.item.latency_in;
            loss_reg    <= scan_in.item.loss_in;
            if (lat_reg != '0)
                jit_reg <= jit_new;
            healthy_reg <= scan_in.item.loss_in < loss_limit;
            stamp_reg   <= now_ticks;
        end
    end

    assign scan_out = scan_reg;

endmodule
